// ----- hw/rtl/etf_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the transmit framer.
package etf_pkg;

	// Header is destination (6), source (6), ethertype (2)
	localparam int HDR_BYTES = 14;
	localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);

	// Result cap per beat accepted on the input side
	localparam int MAX_RESULTS = 64;
	localparam int N_W = $clog2(MAX_RESULTS);
	localparam logic [N_W-1:0] N_LAST = N_W'(MAX_RESULTS - 1);

	// FCS is four bytes, low byte first
	localparam logic [1:0] FCS_LAST = 2'd3;

	localparam logic [31:0] FCS_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

	// One classified input beat
	typedef struct packed {
		logic [7:0] pay_byte;
		logic       last;
		logic       first;
		hdr_t       hdr;
		logic       fcs;
	} item_t;

	// Reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ FCS_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/etf_front.sv -----
// Front end: accepts payload beats and tags the first beat of each frame.
module etf_front import etf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic        payload_last,
	input  logic [47:0] dest_addr,
	input  logic [47:0] src_addr,
	input  logic [15:0] ethertype,
	input  logic        add_fcs,
	output logic        ent_valid,
	input  logic        ent_ready,
	output item_t       ent
);

	logic in_frame_q;
	logic accept;

	assign accept    = in_valid && ent_ready;
	assign in_ready  = ent_ready;
	assign ent_valid = in_valid;

	// Build the queue entry; header fields only matter on the first beat
	always_comb begin
		ent.pay_byte = payload_byte;
		ent.last     = payload_last;
		ent.first    = !in_frame_q;
		ent.hdr      = {dest_addr, src_addr, ethertype};
		ent.fcs      = add_fcs;
	end

	// Frame tracking: open on any beat, close on the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (accept) begin
			in_frame_q <= !payload_last;
		end
	end

endmodule

// ----- hw/rtl/etf_queue.sv -----
// Small FIFO between the front end and the byte sequencer.
module etf_queue import etf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_pop,
	output item_t rd_item
);

	item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               push;
	logic               pop;

	assign wr_ready = cnt_q != QCNT_W'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/etf_back.sv -----
// Byte sequencer: header, payload, pad and FCS, with running CRC and output register.
module etf_back import etf_pkg::*; #(
	parameter int MIN_FRAME = 60
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_pop,
	input  item_t      q_item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_end
);

	localparam int CNT_W = $clog2(MIN_FRAME + 1);
	localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_FRAME);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR  = 3'd1;
	localparam logic [2:0] ST_PAY  = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_FCS  = 3'd4;

	logic [2:0]       state_q;
	logic [3:0]       idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      crc_q;
	logic [N_W-1:0]   n_q;
	logic             fcs_en_q;
	logic [7:0]       byte_q;
	logic             last_q;
	hdr_t             hdr_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             frame_end_q;

	logic [7:0]       cur;
	logic             frame_b;
	logic [31:0]      crc_upd;
	logic [CNT_W-1:0] cnt_inc;
	logic             final_b;
	logic             done;
	logic [2:0]       nxt_state;
	logic [3:0]       nxt_idx;
	logic [1:0]       fcs_word;
	logic [31:0]      fcs_val;
	logic             emit;
	logic             load;

	assign fcs_val  = crc_q ^ CRC_INIT;
	assign emit     = (state_q != ST_IDLE) && (!out_valid_q || out_ready);
	assign load     = q_valid && ((state_q == ST_IDLE) || (emit && done));
	assign q_pop    = load;
	assign fcs_word = idx_q[1:0];

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;

	// Current byte and where the sequence goes next
	always_comb begin
		cur       = '0;
		nxt_state = state_q;
		nxt_idx   = idx_q;
		final_b   = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cur = '0;
			end
			ST_HDR: begin
				cur = hdr_q[HDR_LAST - idx_q];
				if (idx_q == HDR_LAST) begin
					nxt_state = ST_PAY;
					nxt_idx   = '0;
				end else begin
					nxt_idx = idx_q + 1'b1;
				end
			end
			ST_PAY: begin
				cur = byte_q;
			end
			ST_PAD: begin
				cur = '0;
			end
			ST_FCS: begin
				cur = fcs_val[{fcs_word, 3'b000} +: 8];
				if (idx_q[1:0] == FCS_LAST) begin
					final_b = 1'b1;
				end else begin
					nxt_idx = idx_q + 1'b1;
				end
			end
			default: begin
				nxt_state = ST_IDLE;
			end
		endcase

		frame_b = (state_q != ST_FCS);
		crc_upd = crc_byte(crc_q, cur);
		cnt_inc = (cnt_q < MIN_CNT) ? cnt_q + 1'b1 : cnt_q;

		// Payload and pad decide on padding and FCS from the updated count
		if (state_q == ST_PAY && !last_q) begin
			done = 1'b1;
		end else if (state_q == ST_PAY || state_q == ST_PAD) begin
			if (cnt_inc < MIN_CNT) begin
				nxt_state = ST_PAD;
			end else if (fcs_en_q) begin
				nxt_state = ST_FCS;
				nxt_idx   = '0;
			end else begin
				final_b = 1'b1;
			end
		end

		// Result cap on the closing beat: the last kept byte ends the frame
		if (last_q && n_q == N_LAST && state_q != ST_IDLE) begin
			final_b = 1'b1;
		end
		if (final_b) begin
			done = 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= cur;
			frame_end_q <= final_b;
		end
	end

	// Sequencer control and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			crc_q    <= CRC_INIT;
			n_q      <= '0;
			fcs_en_q <= 1'b0;
		end else begin
			if (emit) begin
				if (frame_b) begin
					crc_q <= crc_upd;
					cnt_q <= cnt_inc;
				end
				n_q     <= n_q + 1'b1;
				state_q <= nxt_state;
				idx_q   <= nxt_idx;
				if (final_b) begin
					crc_q    <= CRC_INIT;
					cnt_q    <= '0;
					fcs_en_q <= 1'b0;
				end
				if (done) begin
					state_q <= ST_IDLE;
				end
			end
			if (load) begin
				state_q <= q_item.first ? ST_HDR : ST_PAY;
				idx_q   <= '0;
				n_q     <= '0;
				if (q_item.first) begin
					crc_q    <= CRC_INIT;
					cnt_q    <= '0;
					fcs_en_q <= q_item.fcs;
				end
			end
		end
	end

	// Beat payload held for the sequence
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= q_item.pay_byte;
			last_q <= q_item.last;
			if (q_item.first) begin
				hdr_q <= q_item.hdr;
			end
		end
	end

endmodule

// ----- hw/rtl/ethernet_tx_framer_with_fcs.sv -----
// Top level of the Ethernet transmit framer with optional CRC-32 FCS.
//
// Input channel (in_valid/in_ready): one payload byte per beat, payload_last
// on the final byte. dest_addr, src_addr, ethertype and add_fcs are taken on
// the first beat of a frame and ignored on the others.
// Output channel (out_valid/out_ready): one framed byte per beat, frame_end on
// the final byte (FCS byte 3, or the last pad/payload byte without FCS).
// The first beat of a frame yields the 14 header bytes and the payload byte;
// the last beat yields the payload byte, zero pad up to MIN_FRAME bytes and,
// with add_fcs, the four FCS bytes, low byte first. At most 64 bytes come
// from one beat.
// An accepted beat passes the queue and sequencer into the output register.
// Throughput: one output byte per cycle, set by the back-end sequencer that
// walks header, payload, pad and FCS; mid-frame payload beats pass at one per
// cycle. A two-entry queue lets input beats be taken while the back end works.
// When out_ready is low the output register holds, the sequencer pauses and
// input is taken until the queue is full.
// Reset clears the queue, the frame tracking, the CRC to all ones and the
// output valid; in_ready is high as soon as reset is released.
module ethernet_tx_framer_with_fcs import etf_pkg::*; #(
	parameter int MIN_FRAME = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic        payload_last,
	input  logic [47:0] dest_addr,
	input  logic [47:0] src_addr,
	input  logic [15:0] ethertype,
	input  logic        add_fcs,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end
);

	logic  ent_valid;
	logic  ent_ready;
	item_t ent;
	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	etf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.payload_byte (payload_byte),
		.payload_last (payload_last),
		.dest_addr    (dest_addr),
		.src_addr     (src_addr),
		.ethertype    (ethertype),
		.add_fcs      (add_fcs),
		.ent_valid    (ent_valid),
		.ent_ready    (ent_ready),
		.ent          (ent)
	);

	etf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (ent_valid),
		.wr_ready (ent_ready),
		.wr_item  (ent),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_item  (q_item)
	);

	etf_back #(
		.MIN_FRAME (MIN_FRAME)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

endmodule

// ----- tb/framer_checker.sv -----
// Checker for the transmit framer: predicts framed output bytes and compares them.
`timescale 1ns / 100ps

module framer_checker import etf_pkg::*; #(
	parameter int MIN_FRAME = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  payload_byte,
	input  logic        payload_last,
	input  logic [47:0] dest_addr,
	input  logic [47:0] src_addr,
	input  logic [15:0] ethertype,
	input  logic        add_fcs,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        frame_end,
	output int          err_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] val;
		logic       fin;
	} wire_byte_t;

	// Expected framed bytes, oldest first
	wire_byte_t wire_q[$];

	// Predicted framer state
	logic [31:0] fcs_acc;
	int          frame_len;
	logic        hdr_sent;
	logic        fcs_on;
	int          step_n;

	// Reflected CRC-32, one bit at a time, data LSB first
	function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
		logic [31:0] c;
		logic        fb;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c = c >> 1;
			if (fb)
				c = c ^ FCS_POLY;
		end
		return c;
	endfunction

	// Emit one byte; frame bytes feed the CRC and the length count
	task automatic emit_byte(input logic [7:0] b, input logic counts);
		if (counts) begin
			fcs_acc = crc32_update(fcs_acc, b);
			if (frame_len < MIN_FRAME)
				frame_len++;
		end
		if (step_n < MAX_RESULTS) begin
			wire_q.push_back('{val: b, fin: 1'b0});
			step_n++;
		end
	endtask

	// Work out the framed bytes that one accepted input beat produces
	task automatic frame_beat();
		logic [31:0] fcs;
		step_n = 0;
		if (!hdr_sent) begin
			fcs_on = add_fcs;
			frame_len = 0;
			fcs_acc = CRC_INIT;
			for (int k = 5; k >= 0; k--)
				emit_byte(dest_addr[8*k +: 8], 1'b1);
			for (int k = 5; k >= 0; k--)
				emit_byte(src_addr[8*k +: 8], 1'b1);
			emit_byte(ethertype[15:8], 1'b1);
			emit_byte(ethertype[7:0], 1'b1);
			hdr_sent = 1'b1;
		end
		emit_byte(payload_byte, 1'b1);
		if (payload_last) begin
			// zero pad up to the minimum frame length
			while (frame_len < MIN_FRAME)
				emit_byte(8'h00, 1'b1);
			if (fcs_on) begin
				fcs = ~fcs_acc;
				for (int k = 0; k < 4; k++)
					emit_byte(fcs[8*k +: 8], 1'b0);
			end
			if (step_n > 0)
				wire_q[$].fin = 1'b1;
			hdr_sent = 1'b0;
			fcs_on = 1'b0;
			frame_len = 0;
			fcs_acc = CRC_INIT;
		end
	endtask

	// Predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		wire_byte_t exp_b;
		if (!arst_n) begin
			wire_q.delete();
			fcs_acc = CRC_INIT;
			frame_len = 0;
			hdr_sent = 1'b0;
			fcs_on = 1'b0;
			err_count = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready)
				frame_beat();
			if (out_valid && out_ready) begin
				if (wire_q.size() == 0) begin
					$display("%0t: unexpected beat byte=%02h end=%0b", $time, out_byte, frame_end);
					err_count++;
				end else begin
					exp_b = wire_q.pop_front();
					if (out_byte !== exp_b.val) begin
						$display("%0t: out_byte expected %02h actual %02h", $time, exp_b.val,
							out_byte);
						err_count++;
					end
					if (frame_end !== exp_b.fin) begin
						$display("%0t: frame_end expected %0b actual %0b", $time, exp_b.fin,
							frame_end);
						err_count++;
					end
				end
			end
			pending = wire_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the transmit framer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  payload_byte = '0;
	logic        payload_last = 1'b0;
	logic [47:0] dest_addr = '0;
	logic [47:0] src_addr = '0;
	logic [15:0] ethertype = '0;
	logic        add_fcs = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_end;
	int          errs;
	int          pending;

	// No random idling on either side while set
	logic        calm = 1'b0;
	int          rand_beats;

	localparam int PAT_RANDOM = 0;
	localparam int PAT_ZERO   = 1;
	localparam int PAT_ONES   = 2;

	always #5 clk = ~clk;

	ethernet_tx_framer_with_fcs u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_byte(payload_byte),
		.payload_last(payload_last),
		.dest_addr(dest_addr),
		.src_addr(src_addr),
		.ethertype(ethertype),
		.add_fcs(add_fcs),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.frame_end(frame_end)
	);

	framer_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.payload_byte(payload_byte),
		.payload_last(payload_last),
		.dest_addr(dest_addr),
		.src_addr(src_addr),
		.ethertype(ethertype),
		.add_fcs(add_fcs),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.frame_end(frame_end),
		.err_count(errs),
		.pending(pending)
	);

	// Receiver stalls at random
	always @(negedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 37);
	end

	function automatic logic [47:0] rand_mac();
		return 48'({$urandom(), $urandom()});
	endfunction

	// One input beat: optional idle cycles, then hold valid until accepted
	task automatic send_beat(input logic [7:0] b, input logic lst, input logic [47:0] da,
		input logic [47:0] sa, input logic [15:0] et, input logic fcs);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		payload_byte <= b;
		payload_last <= lst;
		dest_addr <= da;
		src_addr <= sa;
		ethertype <= et;
		add_fcs <= fcs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One frame; header fields on later beats are random and must be ignored
	task automatic send_frame(input int len, input logic [47:0] da, input logic [47:0] sa,
		input logic [15:0] et, input logic fcs, input int pat);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (pat == PAT_ZERO) ? 8'h00 : (pat == PAT_ONES) ? 8'hFF : 8'($urandom());
			if (i == 0)
				send_beat(b, len == 1, da, sa, et, fcs);
			else
				send_beat(b, i == len - 1, rand_mac(), rand_mac(), 16'($urandom()),
					1'($urandom()));
		end
	endtask

	// Let the block drain completely
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	initial begin
		int len;
		int sel;
		logic pause_done;
		pause_done = 1'b0;
		rand_beats = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, single-byte frames, FCS on and off
		send_frame(1, '1, '1, 16'hFFFF, 1'b1, PAT_ONES);
		send_frame(1, '0, '0, 16'h0000, 1'b0, PAT_ZERO);
		send_frame(1, '1, '1, 16'hFFFF, 1'b0, PAT_ONES);
		send_frame(1, '0, '0, 16'h0000, 1'b1, PAT_ZERO);
		send_frame(3, 48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 16'h0800, 1'b1, PAT_RANDOM);
		send_frame(4, 48'hA5A5_5A5A_A5A5, 48'h5A5A_A5A5_5A5A, 16'h86DD, 1'b0, PAT_RANDOM);
		send_frame(2, 48'h8000_0000_0001, 48'h0000_0000_0080, 16'h8100, 1'b1, PAT_RANDOM);

		// Sender holds off until everything has come out
		drain();

		// Random frames: mostly short, some around the pad boundary, some long
		while (rand_beats < 350) begin
			sel = $urandom_range(0, 9);
			if (sel < 5)
				len = $urandom_range(1, 8);
			else if (sel < 8)
				len = $urandom_range(44, 48);
			else
				len = $urandom_range(47, 70);
			calm <= (rand_beats >= 120 && rand_beats < 200);
			send_frame(len, rand_mac(), rand_mac(), 16'($urandom()), 1'($urandom()),
				PAT_RANDOM);
			rand_beats += len;
			if (!pause_done && rand_beats >= 230) begin
				pause_done = 1'b1;
				drain();
			end
		end

		drain();
		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- ethernet_tx_framer_with_fcs.f -----
hw/rtl/etf_pkg.sv
hw/rtl/etf_front.sv
hw/rtl/etf_queue.sv
hw/rtl/etf_back.sv
hw/rtl/ethernet_tx_framer_with_fcs.sv
tb/framer_checker.sv
tb/tb_top.sv
